[rtl/dedup_request_queue_issue_gate_unit_defines.svh]
// Assertion macros for the duplicate-rejecting request queue.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef DEDUP_REQUEST_QUEUE_ISSUE_GATE_UNIT_DEFINES_SVH
`define DEDUP_REQUEST_QUEUE_ISSUE_GATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DRQIG_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DRQIG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DRQIG_ASSERT_SAME(name, clk, rst, ante, cons)
`define DRQIG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[rtl/drqig_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes of the duplicate-rejecting request queue.
// Used by the queue memory, the controller and the top level.
package drqig_pkg;

   localparam int NUM_FLAGS = 5;

   typedef logic [15:0] word_type;
   typedef logic [NUM_FLAGS-1:0][15:0] flags_type;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_SEND   = 3'd1,
      OP_FINISH = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_QUERY  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_DUP      = 3'd2,
      STAT_BUSY     = 3'd3,
      STAT_EMPTY    = 3'd4,
      STAT_NOTFOUND = 3'd5,
      STAT_LINKFAIL = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_COMPARE,
      CS_POP,
      CS_RESULT
   } state_type;

   typedef struct packed {
      logic [2:0] opcode;
      word_type   request_id;
      logic       has_flags;
      flags_type  flags;
      word_type   body_ref;
      logic       link_ok;
   } req_item_type;

   typedef struct packed {
      word_type  request_id;
      flags_type flags;
      word_type  body_ref;
   } entry_type;

   typedef struct packed {
      status_type status;
      word_type   request_id;
      word_type   body_ref;
      flags_type  flags;
      logic [4:0] pending_count;
      logic       outstanding;
   } rsp_item_type;

endpackage

[rtl/drqig_mem.sv]
`timescale 1ns / 1ps
// Queue entry memory: one write port and one read port with registered data.
// Depends on drqig_pkg for the entry type.
module drqig_mem #(
   parameter int QUEUE_DEPTH = 16,
   parameter int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  drqig_pkg::entry_type  wr_data,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output drqig_pkg::entry_type  rd_data
);
   import drqig_pkg::*;

   entry_type mem_array [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/drqig_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the request queue: pointers, issue gate, duplicate search.
// Depends on drqig_pkg and drives the ports of drqig_mem.
module drqig_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int IDX_W = $clog2(QUEUE_DEPTH),
   parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  drqig_pkg::req_item_type req_item,
   output logic                    res_done,
   input  logic                    res_take,
   output drqig_pkg::rsp_item_type res_item,
   output logic                    mem_rd_en,
   output logic [IDX_W-1:0]        mem_rd_addr,
   output logic                    mem_wr_en,
   output logic [IDX_W-1:0]        mem_wr_addr,
   output drqig_pkg::entry_type    mem_wr_data,
   input  drqig_pkg::entry_type    mem_rd_data
);
   import drqig_pkg::*;

   state_type      state_ff, state_in;
   req_item_type   item_ff, req_masked;
   logic [IDX_W-1:0] head_ff, ptr_ff, tail;
   logic [CNT_W-1:0] count_ff, left_ff;
   logic [CNT_W+4:0] cnt_ext;
   logic [IDX_W:0] tail_sum;
   logic           waiting_ff, finished_ff;
   status_type     res_status_ff;
   status_type     dispatch_status;
   word_type       res_id_ff, res_body_ff;
   flags_type      res_flags_ff;
   logic           is_full, is_empty, is_busy, hit, last;
   logic           start_search, start_pop, append_now, append_after;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      req_masked = req_item;
      if (!req_item.has_flags) begin
         req_masked.flags = '0;
      end
   end

   assign tail_sum = {1'b0, head_ff} + (IDX_W+1)'(count_ff);
   assign tail = (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH))
               ? IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

   assign is_full  = count_ff >= CNT_W'(QUEUE_DEPTH);
   assign is_empty = count_ff == '0;
   assign is_busy  = waiting_ff && !finished_ff;
   assign last     = left_ff == CNT_W'(1);
   assign hit = (mem_rd_data.request_id == item_ff.request_id)
             && (item_ff.opcode == OP_QUERY || !item_ff.has_flags
                 || mem_rd_data.flags == item_ff.flags);

   assign start_search = (state_ff == CS_DISPATCH)
      && ((item_ff.opcode == OP_APPEND && !is_full && !is_empty)
          || (item_ff.opcode == OP_QUERY && !is_empty));
   assign start_pop = (state_ff == CS_DISPATCH) && item_ff.opcode == OP_SEND
      && !is_busy && !is_empty;
   assign append_now = (state_ff == CS_DISPATCH) && item_ff.opcode == OP_APPEND
      && !is_full && is_empty;
   assign append_after = (state_ff == CS_COMPARE) && item_ff.opcode == OP_APPEND
      && !hit && last;

   always_comb begin
      dispatch_status = STAT_OK;
      case (item_ff.opcode)
         OP_APPEND: begin
            if (is_full) begin
               dispatch_status = STAT_FULL;
            end
         end
         OP_SEND: begin
            if (is_busy) begin
               dispatch_status = STAT_BUSY;
            end else if (is_empty) begin
               dispatch_status = STAT_EMPTY;
            end
         end
         OP_QUERY: begin
            if (is_empty) begin
               dispatch_status = STAT_NOTFOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_DISPATCH;
            end
         end
         CS_DISPATCH: begin
            if (start_search) begin
               state_in = CS_COMPARE;
            end else if (start_pop) begin
               state_in = CS_POP;
            end else begin
               state_in = CS_RESULT;
            end
         end
         CS_COMPARE: begin
            if (hit || last) begin
               state_in = CS_RESULT;
            end
         end
         CS_POP: begin
            state_in = CS_RESULT;
         end
         CS_RESULT: begin
            if (res_take) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = state_ff == CS_IDLE;
      res_done    = state_ff == CS_RESULT;
      mem_rd_en   = start_search || start_pop
                 || (state_ff == CS_COMPARE && !hit && !last);
      mem_rd_addr = (state_ff == CS_COMPARE) ? wrap_inc(ptr_ff) : head_ff;
      mem_wr_en   = append_now || append_after;
      mem_wr_addr = tail;
      mem_wr_data = '{request_id: item_ff.request_id, flags: item_ff.flags,
                      body_ref: item_ff.body_ref};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CS_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         waiting_ff  <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            CS_DISPATCH: begin
               case (item_ff.opcode)
                  OP_APPEND: begin
                     if (append_now) begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  OP_SEND: begin
                     if (!is_busy) begin
                        waiting_ff  <= 1'b0;
                        finished_ff <= 1'b0;
                     end
                  end
                  OP_FINISH: begin
                     if (waiting_ff) begin
                        finished_ff <= 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     head_ff  <= '0;
                     count_ff <= '0;
                  end
                  default: begin
                  end
               endcase
            end
            CS_COMPARE: begin
               if (append_after) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            CS_POP: begin
               count_ff   <= count_ff - 1'b1;
               head_ff    <= (count_ff == CNT_W'(1)) ? '0 : wrap_inc(head_ff);
               waiting_ff <= item_ff.link_ok;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               item_ff <= req_masked;
            end
         end
         CS_DISPATCH: begin
            ptr_ff        <= head_ff;
            left_ff       <= count_ff;
            res_id_ff     <= '0;
            res_body_ff   <= '0;
            res_flags_ff  <= '0;
            res_status_ff <= dispatch_status;
         end
         CS_COMPARE: begin
            if (hit) begin
               res_status_ff <= (item_ff.opcode == OP_APPEND) ? STAT_DUP : STAT_OK;
            end else if (last) begin
               res_status_ff <= (item_ff.opcode == OP_APPEND) ? STAT_OK : STAT_NOTFOUND;
            end else begin
               ptr_ff  <= wrap_inc(ptr_ff);
               left_ff <= left_ff - 1'b1;
            end
         end
         CS_POP: begin
            res_id_ff     <= mem_rd_data.request_id;
            res_body_ff   <= mem_rd_data.body_ref;
            res_flags_ff  <= mem_rd_data.flags;
            res_status_ff <= item_ff.link_ok ? STAT_OK : STAT_LINKFAIL;
         end
         default: begin
         end
      endcase
   end

   assign cnt_ext = {5'b0, count_ff};

   assign res_item = '{status: res_status_ff, request_id: res_id_ff,
                       body_ref: res_body_ff, flags: res_flags_ff,
                       pending_count: cnt_ext[4:0], outstanding: waiting_ff};

endmodule

[rtl/dedup_request_queue_issue_gate_unit.sv]
`timescale 1ns / 1ps
// Top level of the duplicate-rejecting request queue with a one-request issue gate.
// Depends on drqig_pkg, drqig_mem, drqig_ctrl and the assertion macro header.
//
// Usage: requests enter on the req_ channel and each transaction yields exactly one
// rsp_ transaction. A transaction moves at a rising edge where valid is high and
// stall is low. The opcode selects append, send if available, mark finished, clear
// or query id; the response carries the status, the popped request on a send, the
// queue fill after the operation and the outstanding flag.
// The queue lives in a one-port-read, one-port-write memory with registered read
// data. Append and query walk the queued entries one per cycle after the dispatch
// state, until a match or the last entry; an append to a full queue skips the walk.
// Send with a pop passes through a pop state; everything else goes from dispatch
// straight to the result state.
// The response sits in an output register; the unit takes the next request while
// that register waits on rsp_stall, and it holds a new result back until the
// register is free. Reset empties the queue and clears the outstanding and finished
// flags; the memory contents are not cleared.
`include "dedup_request_queue_issue_gate_unit_defines.svh"
module dedup_request_queue_issue_gate_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_request_id,
   input  logic        req_has_flags,
   input  logic signed [15:0] req_flag_a,
   input  logic signed [15:0] req_flag_b,
   input  logic signed [15:0] req_flag_c,
   input  logic signed [15:0] req_flag_d,
   input  logic signed [15:0] req_flag_e,
   input  logic [15:0] req_body_ref,
   input  logic        req_link_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_request_id,
   output logic [15:0] rsp_out_body_ref,
   output logic signed [15:0] rsp_out_flag_a,
   output logic signed [15:0] rsp_out_flag_b,
   output logic signed [15:0] rsp_out_flag_c,
   output logic signed [15:0] rsp_out_flag_d,
   output logic signed [15:0] rsp_out_flag_e,
   output logic [4:0]  rsp_pending_count,
   output logic        rsp_outstanding
);
   import drqig_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_item_type     req_item;
   rsp_item_type     res_item, rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_ready, res_done, res_take;
   logic             mem_rd_en, mem_wr_en;
   logic [IDX_W-1:0] mem_rd_addr, mem_wr_addr;
   entry_type        mem_wr_data, mem_rd_data;

   assign req_item = '{opcode: req_opcode, request_id: req_request_id,
                       has_flags: req_has_flags,
                       flags: {req_flag_e, req_flag_d, req_flag_c, req_flag_b, req_flag_a},
                       body_ref: req_body_ref, link_ok: req_link_ok};

   drqig_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .res_done    (res_done),
      .res_take    (res_take),
      .res_item    (res_item),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   drqig_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall    = !req_ready;
   assign res_take     = res_done && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res_item;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_out_request_id = rsp_ff.request_id;
   assign rsp_out_body_ref   = rsp_ff.body_ref;
   assign rsp_out_flag_a     = rsp_ff.flags[0];
   assign rsp_out_flag_b     = rsp_ff.flags[1];
   assign rsp_out_flag_c     = rsp_ff.flags[2];
   assign rsp_out_flag_d     = rsp_ff.flags[3];
   assign rsp_out_flag_e     = rsp_ff.flags[4];
   assign rsp_pending_count  = rsp_ff.pending_count;
   assign rsp_outstanding    = rsp_ff.outstanding;

   `DRQIG_ASSERT_SAME(a_busy_has_outstanding, clock, reset, rsp_valid && rsp_status == STAT_BUSY, rsp_outstanding)
   `DRQIG_ASSERT_SAME(a_linkfail_not_outstanding, clock, reset, rsp_valid && rsp_status == STAT_LINKFAIL, !rsp_outstanding)
   `DRQIG_ASSERT_SAME(a_empty_has_no_pending, clock, reset, rsp_valid && rsp_status == STAT_EMPTY, rsp_pending_count == 5'd0)
   `DRQIG_ASSERT_NEXT(a_one_request_at_a_time, clock, reset, req_valid && !req_stall, req_stall)

endmodule
